>>> rtl/ssnf_pkg.sv
// Shared types, constants and the segment table of the seven-segment number formatter.
package ssnf_pkg;

  localparam int unsigned VALUE_W      = 43;
  localparam int unsigned LIMIT_W      = 27;
  localparam int unsigned BCD_DIGITS   = 8;
  localparam int unsigned BCD_W        = 4 * BCD_DIGITS;
  localparam int unsigned ACC_W        = BCD_W + LIMIT_W;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned ROUND_SHIFT  = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_CAP   = 27'd99999999;
  localparam logic [CNT_W-1:0]   DABBLE_LAST = 5'd26;

  typedef struct packed {
    logic [VALUE_W-1:0] value_fixed;
    logic [1:0]         decimals;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] segments;
    logic [3:0] digit_value;
    logic       is_point;
    logic [3:0] position;
    logic       last;
  } out_beat_t;

  // Symbol beat handed from the sequencer to the output register
  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } emit_t;

  typedef enum logic [1:0] {
    ALU_HOLD,
    ALU_TIMES10,
    ALU_ROUND,
    ALU_DABBLE
  } alu_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } state_e;

  // Map one decimal digit to its segment pattern
  function automatic logic [6:0] seg_code(input logic [3:0] digit);
    logic [6:0] code;
    case (digit)
      4'd0: code = 7'h3F;
      4'd1: code = 7'h06;
      4'd2: code = 7'h5B;
      4'd3: code = 7'h4F;
      4'd4: code = 7'h66;
      4'd5: code = 7'h6D;
      4'd6: code = 7'h7D;
      4'd7: code = 7'h07;
      4'd8: code = 7'h7F;
      4'd9: code = 7'h6F;
      default: code = 7'h00;
    endcase
    return code;
  endfunction

endpackage

>>> rtl/ssnf_alu.sv
// Shared arithmetic unit: times-ten step, round and clamp, shift-and-add-3 step.
module ssnf_alu (
  input  ssnf_pkg::alu_op_e                op_i,
  input  logic [ssnf_pkg::ACC_W-1:0]       acc_i,
  input  logic [ssnf_pkg::LIMIT_W-1:0]     limit_i,
  output logic [ssnf_pkg::ACC_W-1:0]       acc_o
);

  localparam int unsigned SUM_W = ssnf_pkg::ACC_W + 1;
  localparam int unsigned QUO_W = SUM_W - ssnf_pkg::ROUND_SHIFT;

  logic [SUM_W-1:0]                round_sum;
  logic [QUO_W-1:0]                round_quo;
  logic [ssnf_pkg::LIMIT_W-1:0]    round_res;
  logic [ssnf_pkg::ACC_W-1:0]      dabble_adj;
  logic [ssnf_pkg::ACC_W-1:0]      times10;

  // Multiply by ten as two shifted copies
  assign times10 = (acc_i << 3) + (acc_i << 1);

  // Add half an LSB, drop the fraction bits, clamp at the limit
  assign round_sum = {1'b0, acc_i} + SUM_W'(1 << (ssnf_pkg::ROUND_SHIFT - 1));
  assign round_quo = round_sum[SUM_W-1:ssnf_pkg::ROUND_SHIFT];

  always_comb begin
    if (round_quo > QUO_W'(limit_i)) begin
      round_res = limit_i;
    end else begin
      round_res = round_quo[ssnf_pkg::LIMIT_W-1:0];
    end
  end

  // Add three to every BCD digit of five or more
  always_comb begin
    dabble_adj = acc_i;
    for (int d = 0; d < ssnf_pkg::BCD_DIGITS; d++) begin
      if (acc_i[ssnf_pkg::LIMIT_W + 4*d +: 4] >= 4'd5) begin
        dabble_adj[ssnf_pkg::LIMIT_W + 4*d +: 4] =
          acc_i[ssnf_pkg::LIMIT_W + 4*d +: 4] + 4'd3;
      end
    end
  end

  // Select the operation
  always_comb begin
    case (op_i)
      ssnf_pkg::ALU_HOLD:    acc_o = acc_i;
      ssnf_pkg::ALU_TIMES10: acc_o = times10;
      ssnf_pkg::ALU_ROUND:   acc_o = {{ssnf_pkg::BCD_W{1'b0}}, round_res};
      ssnf_pkg::ALU_DABBLE:  acc_o = {dabble_adj[ssnf_pkg::ACC_W-2:0], 1'b0};
      default:               acc_o = acc_i;
    endcase
  end

endmodule

>>> rtl/ssnf_seq.sv
// Sequencer: drives the shared unit over scale, convert and symbol emission.
module ssnf_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  ssnf_pkg::in_beat_t            in_beat_i,
  input  logic [ssnf_pkg::LIMIT_W-1:0]  limit_i,
  input  logic                          emit_ready_i,
  output logic                          idle_o,
  output ssnf_pkg::emit_t               emit_o
);

  ssnf_pkg::state_e               state_q, state_d;
  ssnf_pkg::alu_op_e              alu_op;
  logic [ssnf_pkg::ACC_W-1:0]     acc_q, acc_d, alu_res;
  logic [ssnf_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [1:0]                     dec_q, dec_d;
  logic [3:0]                     nw_q, nw_d;
  logic [3:0]                     total_q, total_d;
  logic [3:0]                     k_q, k_d;
  logic [3:0]                     digs [ssnf_pkg::BCD_DIGITS];
  logic [2:0]                     hi_idx;
  logic                           hi_found;
  logic [3:0]                     nw_calc;
  logic                           sym_whole;
  logic                           sym_point;
  logic [4:0]                     idx_whole, idx_frac;
  logic [2:0]                     sym_idx;
  logic [3:0]                     sym_digit;
  logic                           sym_last;

  ssnf_alu u_alu (
    .op_i    (alu_op),
    .acc_i   (acc_q),
    .limit_i (limit_i),
    .acc_o   (alu_res)
  );

  // View the BCD half of the work register as digits
  always_comb begin
    for (int d = 0; d < ssnf_pkg::BCD_DIGITS; d++) begin
      digs[d] = acc_q[ssnf_pkg::LIMIT_W + 4*d +: 4];
    end
  end

  // Find the highest nonzero whole digit
  always_comb begin
    hi_idx   = 3'd0;
    hi_found = 1'b0;
    for (int d = 0; d < ssnf_pkg::BCD_DIGITS; d++) begin
      if ((3'(d) >= {1'b0, dec_q}) && (digs[d] != 4'd0)) begin
        hi_idx   = 3'(d);
        hi_found = 1'b1;
      end
    end
    if (hi_found) begin
      nw_calc = {1'b0, hi_idx} - {2'b00, dec_q} + 4'd1;
    end else begin
      nw_calc = 4'd1;
    end
  end

  // Decode the symbol at the emit position
  assign sym_whole = (k_q < nw_q);
  assign sym_point = (dec_q != 2'd0) && (k_q == nw_q);
  assign idx_whole = 5'(nw_q) + 5'(dec_q) - 5'd1 - 5'(k_q);
  assign idx_frac  = 5'(nw_q) + 5'(dec_q) - 5'(k_q);
  assign sym_idx   = sym_whole ? idx_whole[2:0] : idx_frac[2:0];
  assign sym_digit = sym_point ? 4'd0 : digs[sym_idx];
  assign sym_last  = (k_q == (total_q - 4'd1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ssnf_pkg::ST_IDLE:  if (start_i) state_d = ssnf_pkg::ST_SCALE;
      ssnf_pkg::ST_SCALE: if (cnt_q == '0) state_d = ssnf_pkg::ST_CONV;
      ssnf_pkg::ST_CONV:  if (cnt_q == '0) state_d = ssnf_pkg::ST_SIZE;
      ssnf_pkg::ST_SIZE:  state_d = ssnf_pkg::ST_EMIT;
      ssnf_pkg::ST_EMIT:  if (emit_ready_i && sym_last) state_d = ssnf_pkg::ST_IDLE;
      default:            state_d = ssnf_pkg::ST_IDLE;
    endcase
  end

  // Datapath control and outputs
  always_comb begin
    alu_op      = ssnf_pkg::ALU_HOLD;
    acc_d       = alu_res;
    cnt_d       = cnt_q;
    dec_d       = dec_q;
    nw_d        = nw_q;
    total_d     = total_q;
    k_d         = k_q;
    idle_o      = 1'b0;
    emit_o      = '0;
    case (state_q)
      ssnf_pkg::ST_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          acc_d = ssnf_pkg::ACC_W'(in_beat_i.value_fixed);
          dec_d = in_beat_i.decimals;
          cnt_d = ssnf_pkg::CNT_W'(in_beat_i.decimals);
        end
      end
      ssnf_pkg::ST_SCALE: begin
        if (cnt_q == '0) begin
          alu_op = ssnf_pkg::ALU_ROUND;
          cnt_d  = ssnf_pkg::DABBLE_LAST;
        end else begin
          alu_op = ssnf_pkg::ALU_TIMES10;
          cnt_d  = cnt_q - ssnf_pkg::CNT_W'(1);
        end
      end
      ssnf_pkg::ST_CONV: begin
        alu_op = ssnf_pkg::ALU_DABBLE;
        if (cnt_q != '0) cnt_d = cnt_q - ssnf_pkg::CNT_W'(1);
      end
      ssnf_pkg::ST_SIZE: begin
        nw_d    = nw_calc;
        total_d = nw_calc + ((dec_q != 2'd0) ? ({2'b00, dec_q} + 4'd1) : 4'd0);
        k_d     = 4'd0;
      end
      ssnf_pkg::ST_EMIT: begin
        emit_o.valid            = 1'b1;
        emit_o.beat.segments    = sym_point ? 7'h00 : ssnf_pkg::seg_code(sym_digit);
        emit_o.beat.digit_value = sym_digit;
        emit_o.beat.is_point    = sym_point;
        emit_o.beat.position    = k_q;
        emit_o.beat.last        = sym_last;
        if (emit_ready_i) k_d = k_q + 4'd1;
      end
      default: begin
        idle_o = 1'b0;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssnf_pkg::ST_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      nw_q    <= 4'd1;
      total_q <= 4'd1;
      dec_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      nw_q    <= nw_d;
      total_q <= total_d;
      dec_q   <= dec_d;
    end
  end

  // Advance the work register
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

>>> rtl/seven_segment_number_formatter_unit.sv
// Top level of the seven-segment number formatter: limit register, sequencer, output register.
//
// Usage: present a fixed-point value (27.16 unsigned) and a decimals count
// on the input channel. The block scales it by 10^decimals, rounds half up,
// clamps it at the saturation limit and emits one beat per display symbol:
// whole digits from most significant down (leading zeros dropped, at least
// one kept), then the point tick when decimals is nonzero, then the
// fraction digits. The last beat of a number carries last = 1.
// Sequencing: after acceptance the sequencer runs the times-ten and round
// steps on the shared unit, then the shift-and-add-3 conversion, then sizes
// the number, then emits one symbol per cycle while the output register can
// take a beat. It returns to idle before the next item is accepted, so one
// number is finished before the next is taken.
// The config channel writes the saturation limit; values above 99999999 are
// held as 99999999. Write it only while the block is idle.
// Reset sets the limit to 99999999 and empties the output register.
// A stalled receiver holds the output beat and stalls the sequencer; the
// next item is accepted as soon as the last symbol sits in the output register.
module seven_segment_number_formatter_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ssnf_pkg::in_beat_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ssnf_pkg::out_beat_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ssnf_pkg::LIMIT_W-1:0]   cfg_data_i
);

  logic [ssnf_pkg::LIMIT_W-1:0] limit_q, limit_d;
  logic                         out_valid_q, out_valid_d;
  ssnf_pkg::out_beat_t          out_data_q;
  logic                         idle;
  logic                         emit_ready;
  ssnf_pkg::emit_t              emit;

  ssnf_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_valid_i),
    .in_beat_i    (in_data_i),
    .limit_i      (limit_q),
    .emit_ready_i (emit_ready),
    .idle_o       (idle),
    .emit_o       (emit)
  );

  assign in_ready_o  = idle;
  assign cfg_ready_o = 1'b1;

  // Clamp the limit on write
  always_comb begin
    limit_d = limit_q;
    if (cfg_valid_i) begin
      limit_d = (cfg_data_i > ssnf_pkg::LIMIT_CAP) ? ssnf_pkg::LIMIT_CAP : cfg_data_i;
    end
  end

  // Load the output register when empty or drained this cycle
  assign emit_ready  = !out_valid_q || out_ready_i;
  assign out_valid_d = emit.valid ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= ssnf_pkg::LIMIT_CAP;
      out_valid_q <= 1'b0;
    end else begin
      limit_q     <= limit_d;
      if (emit_ready) out_valid_q <= out_valid_d;
    end
  end

  // Hold the output beat
  always_ff @(posedge clk_i) begin
    if (emit.valid && emit_ready) out_data_q <= emit.beat;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> bench/seven_segment_number_formatter_unit_test.sv
// Testbench for the seven-segment number formatter: directed table, random phases, predictor.
`timescale 1ns / 100ps

module seven_segment_number_formatter_unit_test;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned REPORT_MAX    = 10;
  localparam int unsigned PHASE_ITEMS   = 50;
  localparam int unsigned PHASE_COUNT   = 6;
  localparam logic [3:0]  POINT_GLYPH   = 4'hA;
  localparam logic [ssnf_pkg::LIMIT_W-1:0] LIMIT_ALL_ONES = '1;
  // Segment patterns for digits 0..9, digit 0 in the low bits
  localparam logic [69:0] SEG_ROM = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                     7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

  typedef enum logic {ROW_LIMIT, ROW_ITEM} row_kind_e;

  // Display contents as one nibble per symbol, leftmost symbol in the high nibble
  typedef struct packed {
    logic [3:0]  n_sym;
    logic [35:0] glyphs;
  } readout_t;

  typedef struct packed {
    row_kind_e                    kind;
    logic [ssnf_pkg::VALUE_W-1:0] value;
    logic [1:0]                   dec;
    logic                         typed;
    readout_t                     shown;
  } plan_row_t;

  localparam int unsigned PLAN_ROWS = 27;
  localparam logic [ssnf_pkg::VALUE_W-1:0] VMAX = '1;

  // Directed plan; typed rows carry the display read off by hand
  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_ITEM,  43'h0,             2'd0, 1'b1, '{4'd1, 36'h0}},
    '{ROW_ITEM,  43'h0,             2'd3, 1'b1, '{4'd5, 36'h0A000}},
    '{ROW_ITEM,  VMAX,              2'd0, 1'b1, '{4'd8, 36'h099999999}},
    '{ROW_ITEM,  VMAX,              2'd3, 1'b1, '{4'd9, 36'h99999A999}},
    '{ROW_ITEM,  VMAX,              2'd1, 1'b1, '{4'd9, 36'h9999999A9}},
    '{ROW_ITEM,  VMAX,              2'd2, 1'b1, '{4'd9, 36'h999999A99}},
    '{ROW_ITEM,  43'h10000,         2'd0, 1'b1, '{4'd1, 36'h1}},
    '{ROW_ITEM,  43'h08000,         2'd0, 1'b1, '{4'd1, 36'h1}},
    '{ROW_ITEM,  43'h07FFF,         2'd0, 1'b1, '{4'd1, 36'h0}},
    '{ROW_ITEM,  43'h18000,         2'd1, 1'b1, '{4'd3, 36'h1A5}},
    '{ROW_ITEM,  43'h0_3039_0000,   2'd0, 1'b1, '{4'd5, 36'h12345}},
    '{ROW_ITEM,  43'h1_0932_0000,   2'd0, 1'b1, '{4'd5, 36'h67890}},
    '{ROW_ITEM,  43'h5F5_E0FF_0000, 2'd0, 1'b1, '{4'd8, 36'h099999999}},
    '{ROW_ITEM,  43'h5F5_E100_0000, 2'd0, 1'b1, '{4'd8, 36'h099999999}},
    '{ROW_ITEM,  43'h000_1234_5678, 2'd2, 1'b0, '{4'd0, 36'h0}},
    '{ROW_ITEM,  43'h0AB_CDEF_1234, 2'd3, 1'b0, '{4'd0, 36'h0}},
    '{ROW_ITEM,  43'h000_0003_8000, 2'd0, 1'b0, '{4'd0, 36'h0}},
    '{ROW_ITEM,  43'h000_0000_0001, 2'd3, 1'b0, '{4'd0, 36'h0}},
    '{ROW_LIMIT, 43'd0,             2'd0, 1'b0, '{4'd0, 36'h0}},
    '{ROW_ITEM,  VMAX,              2'd0, 1'b1, '{4'd1, 36'h0}},
    '{ROW_ITEM,  VMAX,              2'd3, 1'b1, '{4'd5, 36'h0A000}},
    '{ROW_LIMIT, 43'd99999,         2'd0, 1'b0, '{4'd0, 36'h0}},
    '{ROW_ITEM,  VMAX,              2'd0, 1'b1, '{4'd5, 36'h99999}},
    '{ROW_ITEM,  VMAX,              2'd3, 1'b1, '{4'd6, 36'h99A999}},
    '{ROW_LIMIT, 43'h7FF_FFFF,      2'd0, 1'b0, '{4'd0, 36'h0}},
    '{ROW_ITEM,  VMAX,              2'd2, 1'b1, '{4'd9, 36'h999999A99}},
    '{ROW_ITEM,  43'h7,             2'd0, 1'b0, '{4'd0, 36'h0}}
  };

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  ssnf_pkg::in_beat_t            in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  ssnf_pkg::out_beat_t           out_data_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [ssnf_pkg::LIMIT_W-1:0]  cfg_data_i  = '0;

  // Limit as the block should hold it, and the symbols still to come
  logic [ssnf_pkg::LIMIT_W-1:0]  shown_limit = 27'd99999999;
  ssnf_pkg::out_beat_t           pending_symbols [$];
  int unsigned         fail_count  = 0;
  int unsigned         cycle_count = 0;
  bit                  rx_steady   = 1'b0;
  bit                  tx_steady   = 1'b0;
  int unsigned         rx_hold     = 0;
  int unsigned         rx_roll;

  seven_segment_number_formatter_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [63:0] ten_pow(logic [1:0] dec);
    logic [63:0] p;
    p = 64'd1;
    for (int j = 0; j < int'(dec); j++) p = p * 64'd10;
    return p;
  endfunction

  // Scale, round half up, clamp, then lay out whole digits, point and fraction
  function automatic readout_t render_readout(logic [ssnf_pkg::VALUE_W-1:0] value,
                                              logic [1:0] dec,
                                              logic [ssnf_pkg::LIMIT_W-1:0] limit);
    logic [63:0] pow10, scaled, cap, whole, frac;
    logic [3:0]  whole_dig [8];
    logic [3:0]  frac_dig [3];
    int          nw;
    readout_t    r;
    pow10  = ten_pow(dec);
    scaled = ({21'b0, value} * pow10 + 64'h8000) >> ssnf_pkg::ROUND_SHIFT;
    cap    = (limit > ssnf_pkg::LIMIT_CAP) ? 64'(ssnf_pkg::LIMIT_CAP) : 64'(limit);
    if (scaled > cap) scaled = cap;
    whole = scaled / pow10;
    frac  = scaled % pow10;
    for (int i = int'(dec) - 1; i >= 0; i--) begin
      frac_dig[i] = 4'(frac % 10);
      frac = frac / 10;
    end
    nw = 0;
    do begin
      whole_dig[nw] = 4'(whole % 10);
      whole = whole / 10;
      nw++;
    end while (whole > 0 && nw < 8);
    r = '0;
    for (int i = nw - 1; i >= 0; i--) begin
      r.glyphs = {r.glyphs[31:0], whole_dig[i]};
      r.n_sym++;
    end
    if (dec > 0) begin
      r.glyphs = {r.glyphs[31:0], POINT_GLYPH};
      r.n_sym++;
      for (int j = 0; j < int'(dec); j++) begin
        r.glyphs = {r.glyphs[31:0], frac_dig[j]};
        r.n_sym++;
      end
    end
    return r;
  endfunction

  // Turn a readout into the symbol beats the block should emit
  task automatic queue_symbols(readout_t r);
    ssnf_pkg::out_beat_t b;
    logic [3:0]          g;
    int                  base;
    for (int k = 0; k < int'(r.n_sym); k++) begin
      base          = (int'(r.n_sym) - 1 - k) * 4;
      g             = r.glyphs[base +: 4];
      b.is_point    = (g == POINT_GLYPH);
      b.digit_value = b.is_point ? 4'd0 : g;
      b.segments    = b.is_point ? 7'd0 : SEG_ROM[int'(g) * 7 +: 7];
      b.position    = 4'(k);
      b.last        = (k == int'(r.n_sym) - 1);
      pending_symbols.push_back(b);
    end
  endtask

  task automatic note_failure(string what, int unsigned want, int unsigned got, int unsigned pos);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("mismatch on %s at position %0d: expected %0d, got %0d", what, pos, want, got);
  endtask

  // Check every accepted output beat against the oldest pending symbol
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_symbols.size() == 0) begin
        note_failure("unexpected beat", 0, 1, 32'(out_data_o.position));
      end else begin
        if (out_data_o.segments != pending_symbols[0].segments)
          note_failure("segments", 32'(pending_symbols[0].segments),
                       32'(out_data_o.segments), 32'(pending_symbols[0].position));
        if (out_data_o.digit_value != pending_symbols[0].digit_value)
          note_failure("digit_value", 32'(pending_symbols[0].digit_value),
                       32'(out_data_o.digit_value), 32'(pending_symbols[0].position));
        if (out_data_o.is_point != pending_symbols[0].is_point)
          note_failure("is_point", 32'(pending_symbols[0].is_point),
                       32'(out_data_o.is_point), 32'(pending_symbols[0].position));
        if (out_data_o.position != pending_symbols[0].position)
          note_failure("position", 32'(pending_symbols[0].position),
                       32'(out_data_o.position), 32'(pending_symbols[0].position));
        if (out_data_o.last != pending_symbols[0].last)
          note_failure("last", 32'(pending_symbols[0].last), 32'(out_data_o.last),
                       32'(pending_symbols[0].position));
        void'(pending_symbols.pop_front());
      end
    end
  end

  // Stall the receiver: mostly ready, short stalls, now and then a long one
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_ready_i = 1'b0;
      rx_hold--;
    end else if (rx_steady) begin
      out_ready_i = 1'b1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 80) begin
        out_ready_i = 1'b1;
      end else if (rx_roll < 97) begin
        out_ready_i = 1'b0;
        rx_hold = $urandom_range(0, 2);
      end else begin
        out_ready_i = 1'b0;
        rx_hold = $urandom_range(10, 40);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("seven_segment_number_formatter_unit verification failed");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (tx_steady || roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  // Random value: mixed magnitudes, values near the limit, exact rounding ties
  function automatic logic [ssnf_pkg::VALUE_W-1:0] pick_value(logic [1:0] dec);
    logic [63:0]                  raw, pow10, target, tie;
    logic [ssnf_pkg::VALUE_W-1:0] mask;
    logic [15:0]                  f;
    int unsigned                  cls, w;
    raw   = {$urandom, $urandom};
    pow10 = ten_pow(dec);
    cls   = $urandom_range(0, 9);
    case (cls)
      0, 1, 2, 3: begin
        w    = $urandom_range(1, ssnf_pkg::VALUE_W);
        mask = (43'd1 << w) - 43'd1;
        return raw[ssnf_pkg::VALUE_W-1:0] & mask;
      end
      4, 5: begin
        target = (shown_limit > ssnf_pkg::LIMIT_CAP) ? 64'(ssnf_pkg::LIMIT_CAP)
                                                     : 64'(shown_limit);
        target = target + $urandom_range(0, 4);
        if (target >= 2) target = target - 2;
        return ssnf_pkg::VALUE_W'(((target << ssnf_pkg::ROUND_SHIFT) +
                                   $urandom_range(0, 65535)) / pow10);
      end
      6: begin
        f = raw[47:32];
        for (int n = 0; n < 65536; n++) begin
          tie = {48'b0, f} * pow10;
          if (tie[15:0] == 16'h8000) break;
          f++;
        end
        return {raw[26:0], f};
      end
      7: return ssnf_pkg::VALUE_W'(raw[19:0]);
      default: return raw[ssnf_pkg::VALUE_W-1:0];
    endcase
  endfunction

  // Present one number; returns at the falling edge after its beat is taken
  task automatic send_number(logic [ssnf_pkg::VALUE_W-1:0] value, logic [1:0] dec, bit typed,
                             readout_t typed_shown);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i            = 1'b1;
    in_data_i.value_fixed = value;
    in_data_i.decimals    = dec;
    do @(posedge clk_i); while (!in_ready_o);
    queue_symbols(typed ? typed_shown : render_readout(value, dec, shown_limit));
    @(negedge clk_i);
  endtask

  // Drop input valid, wait for every symbol, let the block go idle
  task automatic settle();
    in_valid_i = 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_limit(logic [ssnf_pkg::LIMIT_W-1:0] limit);
    cfg_valid_i = 1'b1;
    cfg_data_i  = limit;
    do @(posedge clk_i); while (!cfg_ready_o);
    shown_limit = limit;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    logic [ssnf_pkg::LIMIT_W-1:0] limit;
    logic [1:0]                   dec;
    // Hold reset, then release on a falling edge
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed plan, starting from the reset limit
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_LIMIT) begin
        settle();
        write_limit(plan[i].value[ssnf_pkg::LIMIT_W-1:0]);
      end else begin
        send_number(plan[i].value, plan[i].dec, plan[i].typed, plan[i].shown);
      end
    end

    // Random phases, each under its own limit; one keeps the receiver always ready, one sends with no idle gaps
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      settle();
      case (phase)
        0: limit = 27'($urandom_range(0, 99999999));
        1: limit = 27'd99999;
        2: limit = LIMIT_ALL_ONES;
        3: limit = 27'($urandom_range(0, 999));
        4: limit = ssnf_pkg::LIMIT_CAP;
        default: limit = 27'($urandom);
      endcase
      write_limit(limit);
      rx_steady = (phase == 2);
      tx_steady = (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        dec = 2'($urandom_range(0, 3));
        send_number(pick_value(dec), dec, 1'b0, '0);
      end
    end

    // Drain and report
    rx_steady = 1'b0;
    tx_steady = 1'b0;
    settle();
    if (fail_count == 0 && pending_symbols.size() == 0) begin
      $display("seven_segment_number_formatter_unit verification clean");
    end else begin
      $display("seven_segment_number_formatter_unit verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ssnf_pkg.sv
rtl/ssnf_alu.sv
rtl/ssnf_seq.sv
rtl/seven_segment_number_formatter_unit.sv
bench/seven_segment_number_formatter_unit_test.sv
